[hw/rtl/lstm_pkg.sv]
// ----------------------------------------------------------------------------
// lstm_pkg: shared constants for the light sensor table merge block
// Table geometry, command codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lstm_pkg;

  localparam int NumSensors = 8;
  localparam int NumTurns   = 180;
  localparam int MaxSteps   = 32;
  localparam int TableDepth = MaxSteps * NumTurns * NumSensors;
  localparam int TableAw    = $clog2(TableDepth);
  localparam int SensW      = $clog2(NumSensors);
  localparam int StepW      = 5;
  localparam int CordicIters = 16;

  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdMerge = 2'd1,
    CmdEmit  = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  localparam logic [1:0] RegMinDist  = 2'd0;
  localparam logic [1:0] RegStepLen  = 2'd1;
  localparam logic [1:0] RegStepsUse = 2'd2;

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    case (i)
      4'd0:  atan_turn = 32'd536870912;
      4'd1:  atan_turn = 32'd316933406;
      4'd2:  atan_turn = 32'd167458907;
      4'd3:  atan_turn = 32'd85004756;
      4'd4:  atan_turn = 32'd42667331;
      4'd5:  atan_turn = 32'd21354465;
      4'd6:  atan_turn = 32'd10679838;
      4'd7:  atan_turn = 32'd5340245;
      4'd8:  atan_turn = 32'd2670163;
      4'd9:  atan_turn = 32'd1335087;
      4'd10: atan_turn = 32'd667544;
      4'd11: atan_turn = 32'd333772;
      4'd12: atan_turn = 32'd166886;
      4'd13: atan_turn = 32'd83443;
      4'd14: atan_turn = 32'd41722;
      default: atan_turn = 32'd20861;
    endcase
  endfunction

endpackage

[hw/rtl/lstm_ram.sv]
// ----------------------------------------------------------------------------
// lstm_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module lstm_ram #(
  parameter int Width = 12,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[hw/rtl/light_sensor_table_merge_core.sv]
// ----------------------------------------------------------------------------
// light_sensor_table_merge_core: sampled ambient-light sensor model
// Table of readings, CORDIC range and bearing, max merge and emit.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. A write item keeps
// busy_o high for one cycle; the next item waits until the write is done. A
// merge item runs one CORDIC iteration per cycle (skipped when the light sits
// on the agent), then a range multiply state and a distance state, then a
// restoring divide for the distance step: a setup step and one quotient bit
// per cycle over 37 bits (ending at the setup step when the distance is below
// min_distance). A turn state, an address state and a merge state that walks
// the eight sensors through the single table RAM port, one read per cycle,
// follow; a light past the loaded steps ends after the turn state. An emit
// item puts out one sensor per cycle, each on the result ports for one cycle
// marked by valid_o; the receiver cannot stall, so results are never held.
// Configuration writes are taken at any edge with cfg_we_i high and are
// meant to happen while idle.
// ----------------------------------------------------------------------------
module light_sensor_table_merge_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [30:0]                 cfg_wdata_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  cmd_i,
  input  logic signed [31:0]          agent_x_i,
  input  logic signed [31:0]          agent_y_i,
  input  logic signed [31:0]          light_x_i,
  input  logic signed [31:0]          light_y_i,
  input  logic [30:0]                 agent_radius_i,
  input  logic [15:0]                 agent_heading_i,
  input  logic [4:0]                  table_step_i,
  input  logic [7:0]                  table_turn_i,
  input  logic [2:0]                  table_sensor_i,
  input  logic [11:0]                 table_value_i,
  output logic                        valid_o,
  output logic [2:0]                  sensor_index_o,
  output logic [11:0]                 reading_o,
  output logic                        last_o
);
  import lstm_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StWrite, StCordic, StRange, StDist, StDiv, StTurn, StRead, StMerge,
    StEmit
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [30:0] min_dist_q, step_len_q;
  logic [5:0]  steps_use_q;

  // Captured operands and CORDIC state. The vector grows at most by the
  // CORDIC gain, so 36 bits carry the 33-bit difference safely.
  logic signed [35:0] cx_q, cy_q;
  logic [31:0]        cz_q;
  logic [3:0]         iter_q;
  logic [30:0]        radius_q;
  logic [15:0]        heading_q;
  logic [52:0]        range_q;       // x * 39797, before the shift
  logic signed [40:0] dist_q;
  logic [36:0]        rem_q;         // dividend shifted out bit by bit
  logic [36:0]        quo_q;
  logic [36:0]        part_q;
  logic [5:0]         bit_q;
  logic [7:0]         turn_q;
  logic [4:0]         step_q;
  logic [SensW:0]     sens_q;
  logic [11:0]        acc_q [NumSensors];

  // Table RAM port.
  logic               ram_we;
  logic [TableAw-1:0] ram_addr;
  logic [11:0]        ram_rdata;
  logic [TableAw-1:0] wr_addr_q, base_q;
  logic [11:0]        wr_val_q;

  lstm_ram #(.Width(12), .Depth(TableDepth)) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(wr_val_q),
    .rdata_o(ram_rdata)
  );

  assign ram_we   = (state_q == StWrite);
  assign ram_addr = (state_q == StWrite) ? wr_addr_q :
                    base_q + TableAw'(sens_q[SensW-1:0]);

  // Arithmetic shifts of the CORDIC vector by the iteration count, and the sign of y.
  logic signed [35:0] sh_x, sh_y;
  logic               cy_neg;
  assign sh_x   = cx_q >>> iter_q;
  assign sh_y   = cy_q >>> iter_q;
  assign cy_neg = cy_q[35];

  logic signed [32:0] dx_in, dy_in;
  assign dx_in = 33'(light_x_i) - 33'(agent_x_i);
  assign dy_in = 33'(light_y_i) - 33'(agent_y_i);

  // Divider trial subtraction.
  logic [37:0] trial;
  assign trial = {part_q, rem_q[36]} - {7'd0, step_len_q == 31'd0 ? 31'd1 : step_len_q};

  logic [15:0] rel;
  logic [23:0] turn_prod;
  assign rel       = heading_q - cz_q[31:16];
  assign turn_prod = rel * 8'd180;

  logic signed [40:0] range_s;
  assign range_s = 41'($signed({1'b0, range_q[52:16]}));

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      min_dist_q     <= '0;
      step_len_q     <= 31'd65536;
      steps_use_q    <= '0;
      sens_q         <= '0;
      valid_o        <= 1'b0;
      last_o         <= 1'b0;
      sensor_index_o <= '0;
      reading_o      <= '0;
      cx_q           <= '0;
      cy_q           <= '0;
      cz_q           <= '0;
      iter_q         <= '0;
      radius_q       <= '0;
      heading_q      <= '0;
      range_q        <= '0;
      dist_q         <= '0;
      rem_q          <= '0;
      quo_q          <= '0;
      part_q         <= '0;
      bit_q          <= '0;
      turn_q         <= '0;
      step_q         <= '0;
      wr_addr_q      <= '0;
      base_q         <= '0;
      wr_val_q       <= '0;
      for (int i = 0; i < NumSensors; i++) acc_q[i] <= '0;
    end else begin
      valid_o <= 1'b0;
      last_o  <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMinDist:  min_dist_q  <= cfg_wdata_i;
          RegStepLen:  step_len_q  <= cfg_wdata_i;
          RegStepsUse: steps_use_q <= cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (start_i) begin
            radius_q  <= agent_radius_i;
            heading_q <= agent_heading_i;
            iter_q    <= '0;
            sens_q    <= '0;
            wr_val_q  <= table_value_i;
            wr_addr_q <= TableAw'((32'(table_step_i) * NumTurns + 32'(table_turn_i))
                         * NumSensors + 32'(table_sensor_i));
            case (cmd_e'(cmd_i))
              CmdWrite: begin
                if (table_turn_i < 8'(NumTurns)) state_q <= StWrite;
              end
              CmdMerge: begin
                if (dx_in == '0 && dy_in == '0) begin
                  cx_q <= '0;
                  cz_q <= '0;
                  state_q <= StRange;
                end else if (dx_in[32]) begin
                  cx_q <= -36'(dx_in);
                  cy_q <= -36'(dy_in);
                  cz_q <= 32'h8000_0000;
                  state_q <= StCordic;
                end else begin
                  cx_q <= 36'(dx_in);
                  cy_q <= 36'(dy_in);
                  cz_q <= '0;
                  state_q <= StCordic;
                end
              end
              CmdEmit: state_q <= StEmit;
              default: ;
            endcase
          end
        end
        StWrite: state_q <= StIdle;
        StCordic: begin
          if (!cy_neg) begin
            cx_q <= cx_q + sh_y;
            cy_q <= cy_q - sh_x;
            cz_q <= cz_q + atan_turn(iter_q);
          end else begin
            cx_q <= cx_q - sh_y;
            cy_q <= cy_q + sh_x;
            cz_q <= cz_q - atan_turn(iter_q);
          end
          iter_q <= iter_q + 4'd1;
          if (iter_q == 4'(CordicIters - 1)) state_q <= StRange;
        end
        StRange: begin
          range_q <= 53'(cx_q[35:0]) * 53'd39797;
          state_q <= StDist;
        end
        StDist: begin
          dist_q  <= 41'sd10 * (range_s - 41'($signed({1'b0, radius_q})));
          state_q <= StDiv;
          bit_q   <= '0;
        end
        StDiv: begin
          if (bit_q == '0) begin
            if (dist_q < 41'($signed({1'b0, min_dist_q}))) begin
              quo_q   <= '0;
              state_q <= StTurn;
            end else begin
              rem_q  <= 37'(dist_q - 41'($signed({1'b0, min_dist_q})));
              part_q <= '0;
              quo_q  <= '0;
              bit_q  <= 6'd1;
            end
          end else begin
            if (!trial[37]) begin
              part_q <= trial[36:0];
              quo_q  <= {quo_q[35:0], 1'b1};
            end else begin
              part_q <= {part_q[35:0], rem_q[36]};
              quo_q  <= {quo_q[35:0], 1'b0};
            end
            rem_q <= {rem_q[35:0], 1'b0};
            bit_q <= bit_q + 6'd1;
            if (bit_q == 6'd37) state_q <= StTurn;
          end
        end
        StTurn: begin
          turn_q <= turn_prod[23:16];
          step_q <= quo_q[4:0];
          if (quo_q >= 37'(steps_use_q) || quo_q >= 37'(MaxSteps)) state_q <= StIdle;
          else state_q <= StRead;
        end
        StRead: begin
          base_q  <= TableAw'((32'(step_q) * NumTurns + 32'(turn_q)) * NumSensors);
          sens_q  <= '0;
          state_q <= StMerge;
        end
        StMerge: begin
          // Read data for the previous sensor arrives in the cycle after its address.
          if (sens_q != '0) begin
            if (ram_rdata > acc_q[sens_q[SensW-1:0] - SensW'(1)])
              acc_q[sens_q[SensW-1:0] - SensW'(1)] <= ram_rdata;
          end
          if (sens_q == (SensW+1)'(NumSensors)) state_q <= StIdle;
          else sens_q <= sens_q + (SensW+1)'(1);
        end
        StEmit: begin
          valid_o        <= 1'b1;
          sensor_index_o <= 3'(sens_q[SensW-1:0]);
          reading_o      <= acc_q[sens_q[SensW-1:0]];
          acc_q[sens_q[SensW-1:0]] <= '0;
          last_o         <= (sens_q == (SensW+1)'(NumSensors - 1));
          if (sens_q == (SensW+1)'(NumSensors - 1)) state_q <= StIdle;
          else sens_q <= sens_q + (SensW+1)'(1);
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
